@@ hw/rtl/bmra_pkg.sv @@
// ----------------------------------------------------------------------------
// bmra_pkg
// Shared types, constants and helpers of the bitmap run slot allocator.
// ----------------------------------------------------------------------------
package bmra_pkg;

  localparam int NUM_WORDS_DEF = 16;
  localparam int WORD_W        = 64;
  localparam int OFS_W         = 6;
  localparam int CNT_W         = 7;
  localparam int SLOT_W        = 10;
  localparam int REG_W         = 11;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 16;

  localparam logic [REG_W-1:0] MAX_ELEM_RST = REG_W'(1024);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FAIL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_RESULT
  } fsm_t;

  typedef struct packed {
    logic             hit;
    logic [OFS_W-1:0] offset;
  } scan_res_t;

  // contiguous low mask of count ones; 64 and above is all ones
  function automatic logic [WORD_W-1:0] run_mask(input logic [CNT_W-1:0] count);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (CNT_W'(i) < count) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/bitmap_run_slot_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_run_slot_allocator_unit
// First-fit run allocator over a word-organized occupancy bitmap.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser is the operation (allocate / free),
// tdata holds the count and, for a free, the start slot. Each request gives
// one item on the m_ stream: tdata is the start slot of an allocated run
// (zero on failure and on every free), tuser is the status (1 = failure).
// cfg_we/cfg_wdata write max_elements; write it only while the unit is idle.
//
// The bitmap sits in a RAM, one 64-bit word per row. An allocate reads one
// word per cycle and tests all 64 offsets of that word at once, scanning
// from word 0 until a run fits or the slot limit is reached. A free is a
// read-modify-write of one word. Invalid requests go straight to the result
// state with no RAM access.
// One item is in flight at a time; the result register lets the next
// request be accepted while m_tvalid waits on a stalled m_tready, but a
// second result waits until the first is taken.
// After rst the unit sweeps the RAM to zero, one word a cycle, with s_tready
// low until the last word is written; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module bitmap_run_slot_allocator_unit #(
  parameter int NUM_WORDS = bmra_pkg::NUM_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bmra_pkg::S_TDATA_W-1:0] s_tdata,   // [6:0] request_count, [16:7] start_index
  input  logic                           s_tuser,   // [0] operation
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bmra_pkg::M_TDATA_W-1:0] m_tdata,   // [9:0] slot_index
  output logic                           m_tuser,   // [0] status
  input  logic                           cfg_we,
  input  logic [bmra_pkg::REG_W-1:0]     cfg_wdata
);
  import bmra_pkg::*;

  localparam int AW      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SW      = SLOT_W - OFS_W;
  localparam int LIM_CAP = (NUM_WORDS * WORD_W > 2047) ? 2047 : NUM_WORDS * WORD_W;

  fsm_t state, state_next;

  logic [REG_W-1:0]  max_elements;
  logic [REG_W-1:0]  limit;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     word_idx;
  logic [REG_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] base;
  logic [OFS_W-1:0]  ofs;
  logic [SLOT_W-1:0] res_slot;
  logic              res_status;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic              in_op;
  logic [CNT_W-1:0]  in_cnt;
  logic [SLOT_W-1:0] in_start;
  logic              cnt_ok, alloc_ok, free_ok;
  logic              accept, res_load;
  logic [AW-1:0]     start_word;
  logic [AW+SW-1:0]  start_word_wide;
  logic [CNT_W-1:0]  span;
  logic              more_words;
  scan_res_t         hit;
  logic [SLOT_W+AW+OFS_W-1:0] slot_wide;

  assign in_op    = s_tuser;
  assign in_cnt   = s_tdata[CNT_W-1:0];
  assign in_start = s_tdata[CNT_W+SLOT_W-1:CNT_W];

  assign limit = (max_elements > REG_W'(LIM_CAP)) ? REG_W'(LIM_CAP) : max_elements;

  assign cnt_ok   = (in_cnt != '0) && (in_cnt <= CNT_W'(WORD_W));
  assign alloc_ok = cnt_ok && ({{(REG_W-CNT_W){1'b0}}, in_cnt} <= limit);
  assign free_ok  = cnt_ok &&
                    ({1'b0, in_start} + {{(REG_W-CNT_W){1'b0}}, in_cnt} <= limit);

  assign start_word_wide = {{AW{1'b0}}, in_start[SLOT_W-1:OFS_W]};
  assign start_word      = start_word_wide[AW-1:0];

  // rem counts slots from the current word up to the limit
  assign more_words = rem > REG_W'(WORD_W);
  assign span       = more_words ? CNT_W'(WORD_W) : rem[CNT_W-1:0];

  assign slot_wide = {{SLOT_W{1'b0}}, word_idx, hit.offset};

  assign accept = s_tvalid && s_tready;

  bmra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmra_scan u_scan (
    .word  (mem_rdata),
    .base  (base),
    .count (cnt),
    .span  (span),
    .res   (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = word_idx;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = word_idx;
    res_load   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == AW'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_op == OP_ALLOC && alloc_ok) begin
            mem_re     = 1'b1;
            mem_raddr  = '0;
            state_next = S_SCAN;
          end else if (in_op == OP_FREE && free_ok) begin
            mem_re     = 1'b1;
            mem_raddr  = start_word;
            state_next = S_FREE;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        if (hit.hit) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata | (base << hit.offset);
          state_next = S_RESULT;
        end else if (more_words) begin
          mem_re    = 1'b1;
          mem_raddr = word_idx + AW'(1);
        end else begin
          state_next = S_RESULT;
        end
      end
      S_FREE: begin
        mem_we     = 1'b1;
        mem_wdata  = mem_rdata & ~(base << ofs);
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_elements <= MAX_ELEM_RST;
      clr_addr     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_elements <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request context and result, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt        <= in_cnt;
      base       <= run_mask(in_cnt);
      ofs        <= in_start[OFS_W-1:0];
      rem        <= limit;
      res_slot   <= '0;
      res_status <= (in_op == OP_FREE && free_ok) ? STAT_OK : STAT_FAIL;
      word_idx   <= (in_op == OP_FREE) ? start_word : '0;
    end
    if (state == S_SCAN) begin
      if (hit.hit) begin
        res_slot   <= slot_wide[SLOT_W-1:0];
        res_status <= STAT_OK;
      end else if (more_words) begin
        word_idx <= word_idx + AW'(1);
        rem      <= rem - REG_W'(WORD_W);
      end
    end
    if (res_load) begin
      m_tdata <= {{(M_TDATA_W-SLOT_W){1'b0}}, res_slot};
      m_tuser <= res_status;
    end
  end

  a_hit_sets_count_bits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && hit.hit) |->
      ($countones(mem_wdata) == $countones(mem_rdata) + int'(cnt)))
    else $error("allocation did not set exactly count new bits");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ({1'b0, mem_waddr} < (AW+1)'(NUM_WORDS)))
    else $error("bitmap write beyond last word");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken item");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_FAIL) |-> (m_tdata == '0))
    else $error("failed result carries a nonzero slot");

  a_clear_blocks_input: assert property (@(posedge clk)
    $past(rst) |-> !s_tready)
    else $error("input taken before bitmap clear finished");

endmodule

@@ hw/rtl/bmra_ram.sv @@
// ----------------------------------------------------------------------------
// bmra_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bmra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/bmra_scan.sv @@
// ----------------------------------------------------------------------------
// bmra_scan
// Checks all bit offsets of one bitmap word in parallel, picks the lowest
// offset where a free run of the requested length fits.
// ----------------------------------------------------------------------------
module bmra_scan (
  input  logic [bmra_pkg::WORD_W-1:0] word,
  input  logic [bmra_pkg::WORD_W-1:0] base,
  input  logic [bmra_pkg::CNT_W-1:0]  count,
  input  logic [bmra_pkg::CNT_W-1:0]  span,
  output bmra_pkg::scan_res_t         res
);
  import bmra_pkg::*;

  logic [WORD_W-1:0] fit;

  // span: slots of this word still below the slot limit (1..64)
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      fit[b] = ((CNT_W+1)'(b) + {1'b0, count} <= {1'b0, span}) &&
               ((word & (base << b)) == '0);
    end
  end

  always_comb begin
    res = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (fit[b]) begin
        res.hit    = 1'b1;
        res.offset = OFS_W'(b);
      end
    end
  end

endmodule

@@ sim/tb_bitmap_run_slot_allocator_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_run_slot_allocator_unit
// Self-checking bench for the bitmap run slot allocator. A directed table
// covers the request extremes and the invalid cases, then random phases mix
// allocations, frees of live runs and stray frees under several slot limits.
// Each result item is checked against a bit-level predictor of the bitmap or, for typed rows, against the row.
// ----------------------------------------------------------------------------
module tb_bitmap_run_slot_allocator_unit;
  import bmra_pkg::*;

  localparam int NUM_WORDS     = NUM_WORDS_DEF;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int SETTLE_CYCLES = NUM_WORDS + 8;
  localparam int NUM_PHASES    = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              status;
  } grant_t;

  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } run_t;

  typedef struct packed {
    logic              is_cfg;
    logic [REG_W-1:0]  cfg_value;
    logic              op;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] start;
    logic              typed;
    logic [SLOT_W-1:0] slot;
    logic              status;
  } dir_row_t;

  // cfg | value | op | count | start | typed | slot | status
  localparam dir_row_t DIRECTED [28] = '{
    '{1'b1, 11'd1024, OP_ALLOC, 7'd0,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd1,   10'd0,    1'b1, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd64,  10'd1023, 1'b1, 10'd64, STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd0,   10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd127, 10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd65,  10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_FREE,  7'd0,   10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_FREE,  7'd65,  10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_FREE,  7'd1,   10'd1023, 1'b1, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_FREE,  7'd2,   10'd1023, 1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_FREE,  7'd64,  10'd64,   1'b1, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd63,  10'd0,    1'b0, 10'd0,  STAT_OK},
    // free that runs over the word end
    '{1'b0, 11'd0,    OP_FREE,  7'd10,  10'd60,   1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd4,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_FREE,  7'd5,   10'd100,  1'b1, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd2,   10'd1023, 1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_FREE,  7'd64,  10'd0,    1'b1, 10'd0,  STAT_OK},
    '{1'b1, 11'd0,    OP_ALLOC, 7'd0,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd1,   10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_FREE,  7'd1,   10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b1, 11'd1,    OP_ALLOC, 7'd0,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd1,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd2,   10'd0,    1'b1, 10'd0,  STAT_FAIL},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd1,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b1, 11'd2047, OP_ALLOC, 7'd0,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd64,  10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b1, 11'd70,   OP_ALLOC, 7'd0,   10'd0,    1'b0, 10'd0,  STAT_OK},
    '{1'b0, 11'd0,    OP_ALLOC, 7'd64,  10'd0,    1'b0, 10'd0,  STAT_OK}
  };

  // -1 picks a random limit for that phase
  localparam int PHASE_LIMIT [NUM_PHASES] = '{1024, 2047, 64, 65, 1000, -1, 513, 1, 0, 1024};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{250, 200, 150, 150, 250, 250, 200, 40, 40, 150};

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tuser   = OP_ALLOC;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_we    = 1'b0;
  logic [REG_W-1:0]     cfg_wdata = '0;

  logic [WORD_W-1:0] occupancy [NUM_WORDS];
  logic [REG_W-1:0]  max_elements_q = MAX_ELEM_RST;
  grant_t            expected_grants [$];
  run_t              live_runs [$];
  int                error_count  = 0;
  int                idle_cycles  = 0;
  int                burst_left   = 0;
  bit                sender_gaps  = 1'b1;
  int                sink_mode    = 1;
  int                stall_left   = 0;

  bitmap_run_slot_allocator_unit #(.NUM_WORDS(NUM_WORDS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // first-fit placement inside one word, bounded by the slot limit; a free clears the run in its start word
  function automatic grant_t predict_grant(input logic op, input logic [CNT_W-1:0] count,
                                           input logic [SLOT_W-1:0] start);
    int          limit;
    int          n;
    bit          found;
    logic [WORD_W-1:0] mask;
    grant_t      g;
    limit = (int'(max_elements_q) < NUM_WORDS * WORD_W) ? int'(max_elements_q)
                                                        : NUM_WORDS * WORD_W;
    n     = int'(count);
    mask  = (n >= WORD_W) ? '1 : ((64'd1 << n) - 64'd1);
    found = 1'b0;
    g.slot   = '0;
    g.status = STAT_FAIL;
    if (op == OP_ALLOC) begin
      if (n >= 1 && n <= WORD_W && n <= limit) begin
        for (int w = 0; w < NUM_WORDS && !found && w * WORD_W < limit; w++) begin
          for (int b = 0; b + n <= WORD_W && w * WORD_W + b + n <= limit; b++) begin
            if ((occupancy[w] & (mask << b)) == '0) begin
              occupancy[w] |= mask << b;
              g.slot   = SLOT_W'(w * WORD_W + b);
              g.status = STAT_OK;
              found    = 1'b1;
              break;
            end
          end
        end
      end
    end else if (n >= 1 && n <= WORD_W && int'(start) + n <= limit) begin
      // bits past the end of the start word are dropped
      occupancy[start / WORD_W] &= ~(mask << start[OFS_W-1:0]);
      g.status = STAT_OK;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic send_request(input logic op, input logic [CNT_W-1:0] count,
                              input logic [SLOT_W-1:0] start, input logic typed,
                              input grant_t typed_grant);
    grant_t g;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= S_TDATA_W'({start, count});
    do @(posedge clk); while (!s_tready);
    g = predict_grant(op, count, start);
    expected_grants.push_back(typed ? typed_grant : g);
    if (op == OP_ALLOC && g.status == STAT_OK) begin
      live_runs.push_back('{g.slot, count});
    end
    if (sender_gaps) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(0, 9);
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait until every item has come back and the unit is idle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_elements(input logic [REG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    max_elements_q = value;
  endtask

  // result checker and stall pattern of the receiver
  always @(posedge clk) begin
    grant_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result item", int'(m_tdata), -1);
        end else begin
          want = expected_grants.pop_front();
          if (m_tdata[SLOT_W-1:0] !== want.slot) begin
            report_mismatch("slot_index", int'(m_tdata[SLOT_W-1:0]), int'(want.slot));
          end
          if (m_tuser !== want.status) begin
            report_mismatch("status", int'(m_tuser), int'(want.status));
          end
        end
      end
      case (sink_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(1, 20);
            m_tready <= 1'b0;
          end else begin
            m_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                cfg_value;
    int                r;
    int                pick;
    logic              op;
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] start;
    for (int w = 0; w < NUM_WORDS; w++) begin
      occupancy[w] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        drain_results();
        set_max_elements(DIRECTED[i].cfg_value);
      end else begin
        send_request(DIRECTED[i].op, DIRECTED[i].count, DIRECTED[i].start,
                     DIRECTED[i].typed, '{DIRECTED[i].slot, DIRECTED[i].status});
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      cfg_value   = (PHASE_LIMIT[p] < 0) ? $urandom_range(2, 1023) : PHASE_LIMIT[p];
      set_max_elements(REG_W'(cfg_value));
      sender_gaps = (p % 3 != 0);
      sink_mode   = p % 3;
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        r     = $urandom_range(0, 99);
        start = SLOT_W'($urandom_range(0, 1023));
        if (r < ((live_runs.size() < 30) ? 55 : 35)) begin
          op = OP_ALLOC;
          r  = $urandom_range(0, 99);
          if (r < 70)      count = CNT_W'($urandom_range(1, 8));
          else if (r < 90) count = CNT_W'($urandom_range(9, 64));
          else if (r < 95) count = CNT_W'(64);
          else if (r < 97) count = '0;
          else             count = CNT_W'($urandom_range(65, 127));
        end else if (r < 88 && live_runs.size() != 0) begin
          op    = OP_FREE;
          pick  = $urandom_range(0, live_runs.size() - 1);
          start = live_runs[pick].start;
          count = live_runs[pick].count;
          live_runs.delete(pick);
        end else begin
          // stray free: random place, count may be invalid
          op    = OP_FREE;
          count = ($urandom_range(0, 1) != 0) ? CNT_W'($urandom_range(1, 64))
                                              : CNT_W'($urandom_range(0, 127));
        end
        send_request(op, count, start, 1'b0, '0);
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
